>>> rtl/ordered_child_list_with_cursor_unit_assert.svh
// Assertion macros for the ordered child list RTL; oclc_engine uses them.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ORDERED_CHILD_LIST_WITH_CURSOR_UNIT_ASSERT_SVH
`define ORDERED_CHILD_LIST_WITH_CURSOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OCLC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OCLC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/oclc_pkg.sv
// Shared types, codes and sizes for the ordered child list unit.
// No dependencies; the design files and the testbench refer to it by scoped names.
package oclc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ID_BITS     = 16;
  localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS    = ADDR_BITS + 1;
  localparam int REV_BITS    = 32;

  localparam logic [ID_BITS-1:0] ID_NONE = '1;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_REPLACE = 3'd2;
  localparam logic [2:0] CMD_MOVE    = 3'd3;
  localparam logic [2:0] CMD_FIND    = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_INVALID   = 3'd1;
  localparam logic [2:0] STATUS_CAPACITY  = 3'd2;
  localparam logic [2:0] STATUS_EXISTS    = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [ID_BITS-1:0]  child_id;
    logic [ID_BITS-1:0]  new_id;
    logic [CNT_BITS-1:0] position;
    logic                append;
  } in_req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [CNT_BITS-1:0]  entry_count;
    logic                 cursor_valid;
    logic [ADDR_BITS-1:0] cursor_position;
    logic [CNT_BITS-1:0]  found_position;
    logic [REV_BITS-1:0]  revision;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [ID_BITS-1:0]   wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/oclc_id_mem.sv
// ID storage: one write port, one read port, registered read data.
// Depends on oclc_pkg for sizes and the port request struct.
module oclc_id_mem (
  input  logic                        clk,
  input  oclc_pkg::mem_req_t          mem_req,
  output logic [oclc_pkg::ID_BITS-1:0] rd_data
);

  logic [oclc_pkg::ID_BITS-1:0] mem [oclc_pkg::MAX_ENTRIES];
  logic [oclc_pkg::ID_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/oclc_engine.sv
// Command sequencer: scans the ID memory, checks the request, shifts
// entries and keeps count, cursor and revision. Uses oclc_pkg and the
// assertion macro header.
`include "ordered_child_list_with_cursor_unit_assert.svh"

module oclc_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accepts_children,
  input  logic                         req_valid,
  input  oclc_pkg::in_req_t            req,
  output logic                         req_stall,
  output logic                         res_valid,
  input  logic                         res_take,
  output oclc_pkg::result_t            res,
  output oclc_pkg::mem_req_t           mem_req,
  input  logic [oclc_pkg::ID_BITS-1:0] rd_data
);

  localparam int AW = oclc_pkg::ADDR_BITS;
  localparam int CW = oclc_pkg::CNT_BITS;
  localparam logic [CW-1:0] FULL = CW'(oclc_pkg::MAX_ENTRIES);

  oclc_pkg::state_t  state_r, state_nxt;
  oclc_pkg::in_req_t req_r, req_nxt;
  oclc_pkg::result_t res_r, res_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic                        cur_vld_r, cur_vld_nxt;
  logic [AW-1:0]               cur_idx_r, cur_idx_nxt;
  logic [oclc_pkg::REV_BITS-1:0] rev_r, rev_nxt;

  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic          fid_r, fid_nxt;
  logic [AW-1:0] fpos_r, fpos_nxt;
  logic          fnid_r, fnid_nxt;

  logic [AW-1:0] sh_dst_r, sh_dst_nxt;
  logic [CW-1:0] sh_left_r, sh_left_nxt;
  logic          sh_up_r, sh_up_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_dst_r, wr_dst_nxt;

  logic                         fin_en_r, fin_en_nxt;
  logic [AW-1:0]                fin_addr_r, fin_addr_nxt;
  logic [oclc_pkg::ID_BITS-1:0] fin_data_r, fin_data_nxt;

  // Decision, valid only in S_DECIDE
  logic [2:0]    d_status;
  logic [CW-1:0] d_count;
  logic          d_cv;
  logic [AW-1:0] d_ci;
  logic          d_rev_inc;
  logic [CW-1:0] d_found;
  logic [AW-1:0] d_sh_dst;
  logic [CW-1:0] d_sh_left;
  logic          d_sh_up;
  logic          d_fin_en;
  logic [AW-1:0] d_fin_addr;
  logic [oclc_pkg::ID_BITS-1:0] d_fin_data;

  always_comb begin
    logic [CW-1:0] ins_pos;
    logic [CW-1:0] fpos_w;
    logic [CW-1:0] cur_w;
    logic [CW-1:0] new_cnt;
    logic [CW-1:0] last_w;
    logic [CW-1:0] np;
    ins_pos = req_r.append ? count_r : req_r.position;
    fpos_w  = {1'b0, fpos_r};
    cur_w   = {1'b0, cur_idx_r};
    new_cnt = count_r - CW'(1);
    last_w  = new_cnt - CW'(1);
    np      = req_r.position;

    d_status   = oclc_pkg::STATUS_OK;
    d_count    = count_r;
    d_cv       = cur_vld_r;
    d_ci       = cur_idx_r;
    d_rev_inc  = 1'b0;
    d_found    = FULL;
    d_sh_dst   = '0;
    d_sh_left  = '0;
    d_sh_up    = 1'b0;
    d_fin_en   = 1'b0;
    d_fin_addr = '0;
    d_fin_data = req_r.child_id;

    case (req_r.cmd)
      oclc_pkg::CMD_INSERT: begin
        if (!accepts_children || req_r.child_id == oclc_pkg::ID_NONE) begin
          d_status = oclc_pkg::STATUS_INVALID;
        end else if (count_r >= FULL) begin
          d_status = oclc_pkg::STATUS_CAPACITY;
        end else if (fid_r) begin
          d_status = oclc_pkg::STATUS_EXISTS;
        end else if (ins_pos > count_r) begin
          d_status = oclc_pkg::STATUS_INVALID;
        end else begin
          // open a hole at ins_pos by moving the tail up one place
          d_sh_dst   = count_r[AW-1:0];
          d_sh_left  = count_r - ins_pos;
          d_sh_up    = 1'b0;
          d_fin_en   = 1'b1;
          d_fin_addr = ins_pos[AW-1:0];
          d_count    = count_r + CW'(1);
          d_rev_inc  = 1'b1;
          if (!cur_vld_r) begin
            d_cv = 1'b1;
            d_ci = '0;
          end else if (ins_pos <= cur_w) begin
            d_ci = cur_idx_r + AW'(1);
          end
        end
      end
      oclc_pkg::CMD_REMOVE: begin
        if (!fid_r) begin
          d_status = oclc_pkg::STATUS_NOT_FOUND;
        end else begin
          d_sh_dst  = fpos_r;
          d_sh_left = new_cnt - fpos_w;
          d_sh_up   = 1'b1;
          d_count   = new_cnt;
          d_rev_inc = 1'b1;
          if (new_cnt == '0) begin
            d_cv = 1'b0;
            d_ci = '0;
          end else if (cur_vld_r) begin
            if (cur_idx_r == fpos_r) begin
              d_ci = (fpos_w < new_cnt) ? fpos_r : last_w[AW-1:0];
            end else if (cur_idx_r > fpos_r) begin
              d_ci = cur_idx_r - AW'(1);
            end
          end
        end
      end
      oclc_pkg::CMD_REPLACE: begin
        if (req_r.new_id == oclc_pkg::ID_NONE) begin
          d_status = oclc_pkg::STATUS_INVALID;
        end else if (fnid_r) begin
          d_status = oclc_pkg::STATUS_EXISTS;
        end else if (!fid_r) begin
          d_status = oclc_pkg::STATUS_NOT_FOUND;
        end else begin
          d_fin_en   = 1'b1;
          d_fin_addr = fpos_r;
          d_fin_data = req_r.new_id;
          d_rev_inc  = 1'b1;
        end
      end
      oclc_pkg::CMD_MOVE: begin
        if (np >= count_r) begin
          d_status = oclc_pkg::STATUS_INVALID;
        end else if (!fid_r) begin
          d_status = oclc_pkg::STATUS_NOT_FOUND;
        end else if (np != fpos_w) begin
          d_sh_dst   = fpos_r;
          d_sh_up    = (fpos_w < np);
          d_sh_left  = (fpos_w < np) ? (np - fpos_w) : (fpos_w - np);
          d_fin_en   = 1'b1;
          d_fin_addr = np[AW-1:0];
          d_rev_inc  = 1'b1;
          if (cur_vld_r) begin
            if (cur_idx_r == fpos_r) begin
              d_ci = np[AW-1:0];
            end else if (fpos_w < cur_w && np >= cur_w) begin
              d_ci = cur_idx_r - AW'(1);
            end else if (fpos_w > cur_w && np <= cur_w) begin
              d_ci = cur_idx_r + AW'(1);
            end
          end
        end
      end
      oclc_pkg::CMD_FIND: begin
        d_found = fid_r ? fpos_w : FULL;
      end
      default: begin
        d_status = oclc_pkg::STATUS_INVALID;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oclc_pkg::S_IDLE:   if (req_valid) state_nxt = oclc_pkg::S_SCAN;
      oclc_pkg::S_SCAN:   if (rd_idx_r >= count_r && !chk_vld_r) begin
        state_nxt = oclc_pkg::S_DECIDE;
      end
      oclc_pkg::S_DECIDE: state_nxt = oclc_pkg::S_SHIFT;
      oclc_pkg::S_SHIFT:  if (sh_left_r == '0 && !wr_pend_r) begin
        state_nxt = oclc_pkg::S_FINAL;
      end
      oclc_pkg::S_FINAL:  state_nxt = oclc_pkg::S_DONE;
      oclc_pkg::S_DONE:   if (res_take) state_nxt = oclc_pkg::S_IDLE;
      default:            state_nxt = oclc_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory port
  always_comb begin
    req_nxt      = req_r;
    res_nxt      = res_r;
    count_nxt    = count_r;
    cur_vld_nxt  = cur_vld_r;
    cur_idx_nxt  = cur_idx_r;
    rev_nxt      = rev_r;
    rd_idx_nxt   = rd_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    fid_nxt      = fid_r;
    fpos_nxt     = fpos_r;
    fnid_nxt     = fnid_r;
    sh_dst_nxt   = sh_dst_r;
    sh_left_nxt  = sh_left_r;
    sh_up_nxt    = sh_up_r;
    wr_pend_nxt  = wr_pend_r;
    wr_dst_nxt   = wr_dst_r;
    fin_en_nxt   = fin_en_r;
    fin_addr_nxt = fin_addr_r;
    fin_data_nxt = fin_data_r;
    mem_req      = '0;

    unique case (state_r)
      oclc_pkg::S_IDLE: begin
        if (req_valid) begin
          req_nxt     = req;
          rd_idx_nxt  = '0;
          chk_vld_nxt = 1'b0;
          fid_nxt     = 1'b0;
          fpos_nxt    = '0;
          fnid_nxt    = 1'b0;
        end
      end
      oclc_pkg::S_SCAN: begin
        // one read issued per cycle, compared in the next cycle
        if (rd_idx_r < count_r) begin
          mem_req.re  = 1'b1;
          mem_req.raddr = rd_idx_r[AW-1:0];
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (rd_data == req_r.child_id) begin
            fid_nxt  = 1'b1;
            fpos_nxt = chk_idx_r;
          end
          if (rd_data == req_r.new_id) begin
            fnid_nxt = 1'b1;
          end
        end
      end
      oclc_pkg::S_DECIDE: begin
        res_nxt.status         = d_status;
        res_nxt.found_position = d_found;
        count_nxt    = d_count;
        cur_vld_nxt  = d_cv;
        cur_idx_nxt  = d_ci;
        rev_nxt      = rev_r + oclc_pkg::REV_BITS'(d_rev_inc);
        sh_dst_nxt   = d_sh_dst;
        sh_left_nxt  = d_sh_left;
        sh_up_nxt    = d_sh_up;
        wr_pend_nxt  = 1'b0;
        fin_en_nxt   = d_fin_en;
        fin_addr_nxt = d_fin_addr;
        fin_data_nxt = d_fin_data;
      end
      oclc_pkg::S_SHIFT: begin
        // read the neighbor of the next destination, write it back in the next cycle
        if (sh_left_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = sh_up_r ? (sh_dst_r + AW'(1)) : (sh_dst_r - AW'(1));
          wr_pend_nxt   = 1'b1;
          wr_dst_nxt    = sh_dst_r;
          sh_dst_nxt    = sh_up_r ? (sh_dst_r + AW'(1)) : (sh_dst_r - AW'(1));
          sh_left_nxt   = sh_left_r - CW'(1);
        end else begin
          wr_pend_nxt = 1'b0;
        end
        if (wr_pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_dst_r;
          mem_req.wdata = rd_data;
        end
      end
      oclc_pkg::S_FINAL: begin
        if (fin_en_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = fin_addr_r;
          mem_req.wdata = fin_data_r;
        end
        res_nxt.entry_count     = count_r;
        res_nxt.cursor_valid    = cur_vld_r;
        res_nxt.cursor_position = cur_vld_r ? cur_idx_r : '0;
        res_nxt.revision        = rev_r;
      end
      oclc_pkg::S_DONE: begin
        // hold the result until the output register takes it
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= oclc_pkg::S_IDLE;
      count_r   <= '0;
      cur_vld_r <= 1'b0;
      cur_idx_r <= '0;
      rev_r     <= oclc_pkg::REV_BITS'(1);
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
      fid_r     <= 1'b0;
      fnid_r    <= 1'b0;
      sh_left_r <= '0;
      wr_pend_r <= 1'b0;
      fin_en_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cur_vld_r <= cur_vld_nxt;
      cur_idx_r <= cur_idx_nxt;
      rev_r     <= rev_nxt;
      rd_idx_r  <= rd_idx_nxt;
      chk_vld_r <= chk_vld_nxt;
      fid_r     <= fid_nxt;
      fnid_r    <= fnid_nxt;
      sh_left_r <= sh_left_nxt;
      wr_pend_r <= wr_pend_nxt;
      fin_en_r  <= fin_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    chk_idx_r  <= chk_idx_nxt;
    fpos_r     <= fpos_nxt;
    sh_dst_r   <= sh_dst_nxt;
    sh_up_r    <= sh_up_nxt;
    wr_dst_r   <= wr_dst_nxt;
    fin_addr_r <= fin_addr_nxt;
    fin_data_r <= fin_data_nxt;
  end

  assign req_stall = (state_r != oclc_pkg::S_IDLE);
  assign res_valid = (state_r == oclc_pkg::S_DONE);
  assign res       = res_r;

  `OCLC_ASSERT_IMPL(a_cursor_tracks_count, 1'b1, cur_vld_r == (count_r != '0), "cursor valid out of step with count")
  `OCLC_ASSERT_IMPL(a_cursor_in_list, cur_vld_r, {1'b0, cur_idx_r} < count_r, "cursor beyond last entry")
  `OCLC_ASSERT_IMPL(a_no_write_in_scan, state_r == oclc_pkg::S_SCAN, !mem_req.we, "memory write during scan")
  `OCLC_ASSERT_IMPL(a_shift_no_overlap, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "shift reads the entry it writes")
  `OCLC_ASSERT_NEXT(a_rev_only_on_decide, state_r != oclc_pkg::S_DECIDE, rev_r == $past(rev_r), "revision changed outside decide")

endmodule

>>> rtl/ordered_child_list_with_cursor_unit.sv
// Ordered child list unit: ID memory, command sequencer, output register
// and the container configuration bit. Depends on oclc_pkg, oclc_id_mem
// and oclc_engine.
//
// One request at a time. A request is taken in an idle cycle. It then
// scans the ID memory (one read a cycle, each compared in the next
// cycle) and decides. It then shifts the entries moved by insert,
// remove or move, makes the final write of the new ID for insert,
// replace or move, and hands the result to the output register. The
// scan and the shift share the single read port of the ID memory. The
// next request is taken once the result sits in the output register,
// even while it waits to be taken.
module ordered_child_list_with_cursor_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  oclc_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output oclc_pkg::result_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  logic                         acc_r;
  logic                         out_vld_r, out_vld_nxt;
  oclc_pkg::result_t            out_data_r, out_data_nxt;
  logic                         res_valid, res_take;
  oclc_pkg::result_t            res;
  oclc_pkg::mem_req_t           mem_req;
  logic [oclc_pkg::ID_BITS-1:0] rd_data;

  oclc_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .accepts_children (acc_r),
    .req_valid        (in_valid),
    .req              (in_data),
    .req_stall        (in_stall),
    .res_valid        (res_valid),
    .res_take         (res_take),
    .res              (res),
    .mem_req          (mem_req),
    .rd_data          (rd_data)
  );

  oclc_id_mem u_id_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // load when the slot is empty or drains this cycle
  assign res_take = res_valid && (!out_vld_r || !out_stall);

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (res_take) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = res;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        acc_r <= cfg_wr_data;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for ordered_child_list_with_cursor_unit.
// Runs directed and random list commands against a built-in predictor of the
// list, cursor and revision state. Depends on oclc_pkg and the unit's RTL.
module testbench;

  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE     = 24;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 310;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  oclc_pkg::in_req_t in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  oclc_pkg::result_t out_data;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_wr_data = 1'b1;

  ordered_child_list_with_cursor_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Predicted list state
  logic [oclc_pkg::ID_BITS-1:0]  ids [oclc_pkg::MAX_ENTRIES];
  int                            cnt = 0;
  bit                            cur_v = 1'b0;
  int                            cur_i = 0;
  logic [oclc_pkg::REV_BITS-1:0] rev = oclc_pkg::REV_BITS'(1);
  bit                            container = 1'b1;

  oclc_pkg::in_req_t            pending_requests[$];
  oclc_pkg::result_t            list_results[$];
  logic [oclc_pkg::ID_BITS-1:0] id_pool [POOL_SIZE];

  int                cycle_count = 0;
  int                error_count = 0;
  int                requests_queued = 0;
  int                results_seen = 0;
  int                n_rejected = 0;
  int                n_finds = 0;
  int                max_fill = 0;
  bit                req_taken = 1'b0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                stall_mode = 0;
  int                stall_hold = 0;
  oclc_pkg::result_t want_res;

  function automatic int where_is(input logic [oclc_pkg::ID_BITS-1:0] key);
    for (int i = 0; i < cnt; i++) begin
      if (ids[i] == key) return i;
    end
    return oclc_pkg::MAX_ENTRIES;
  endfunction

  // Apply one request to the predicted state and return the result it gives.
  function automatic oclc_pkg::result_t list_update(input oclc_pkg::in_req_t r);
    oclc_pkg::result_t res;
    logic [2:0]        st;
    int                found;
    int                p;
    int                op;
    int                i;
    st = oclc_pkg::STATUS_OK;
    found = oclc_pkg::MAX_ENTRIES;
    case (r.cmd)
      oclc_pkg::CMD_INSERT: begin
        p = r.append ? cnt : int'(r.position);
        if (!container || r.child_id == oclc_pkg::ID_NONE) st = oclc_pkg::STATUS_INVALID;
        else if (cnt >= oclc_pkg::MAX_ENTRIES) st = oclc_pkg::STATUS_CAPACITY;
        else if (where_is(r.child_id) < oclc_pkg::MAX_ENTRIES) st = oclc_pkg::STATUS_EXISTS;
        else if (p > cnt) st = oclc_pkg::STATUS_INVALID;
        else begin
          for (i = cnt; i > p; i--) ids[i] = ids[i-1];
          ids[p] = r.child_id;
          cnt++;
          if (!cur_v) begin
            cur_v = 1'b1;
            cur_i = 0;
          end else if (p <= cur_i) begin
            cur_i++;
          end
          rev++;
        end
      end
      oclc_pkg::CMD_REMOVE: begin
        op = where_is(r.child_id);
        if (op >= oclc_pkg::MAX_ENTRIES) st = oclc_pkg::STATUS_NOT_FOUND;
        else begin
          for (i = op; i + 1 < cnt; i++) ids[i] = ids[i+1];
          cnt--;
          if (cnt == 0) begin
            cur_v = 1'b0;
            cur_i = 0;
          end else if (cur_v) begin
            // clamp an active entry that fell off the end
            if (cur_i == op) cur_i = (op < cnt) ? op : cnt - 1;
            else if (cur_i > op) cur_i--;
          end
          rev++;
        end
      end
      oclc_pkg::CMD_REPLACE: begin
        op = where_is(r.child_id);
        if (r.new_id == oclc_pkg::ID_NONE) st = oclc_pkg::STATUS_INVALID;
        else if (where_is(r.new_id) < oclc_pkg::MAX_ENTRIES) st = oclc_pkg::STATUS_EXISTS;
        else if (op >= oclc_pkg::MAX_ENTRIES) st = oclc_pkg::STATUS_NOT_FOUND;
        else begin
          ids[op] = r.new_id;
          rev++;
        end
      end
      oclc_pkg::CMD_MOVE: begin
        p = int'(r.position);
        op = where_is(r.child_id);
        if (p >= cnt) st = oclc_pkg::STATUS_INVALID;
        else if (op >= oclc_pkg::MAX_ENTRIES) st = oclc_pkg::STATUS_NOT_FOUND;
        else if (op != p) begin
          if (op < p) for (i = op; i < p; i++) ids[i] = ids[i+1];
          else for (i = op; i > p; i--) ids[i] = ids[i-1];
          ids[p] = r.child_id;
          if (cur_v) begin
            if (cur_i == op) cur_i = p;
            else if (op < cur_i && p >= cur_i) cur_i--;
            else if (op > cur_i && p <= cur_i) cur_i++;
          end
          rev++;
        end
      end
      oclc_pkg::CMD_FIND: begin
        found = where_is(r.child_id);
        n_finds++;
      end
      default: st = oclc_pkg::STATUS_INVALID;
    endcase
    if (st != oclc_pkg::STATUS_OK) n_rejected++;
    if (cnt > max_fill) max_fill = cnt;
    res.status          = st;
    res.entry_count     = oclc_pkg::CNT_BITS'(cnt);
    res.cursor_valid    = cur_v;
    res.cursor_position = cur_v ? oclc_pkg::ADDR_BITS'(cur_i) : '0;
    res.found_position  = oclc_pkg::CNT_BITS'(found);
    res.revision        = rev;
    return res;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Accept requests into the predictor and check results in order
  always @(posedge clk) begin
    cycle_count++;
    req_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (list_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          want_res = list_results.pop_front();
          check_field("status", 32'(want_res.status), 32'(out_data.status));
          check_field("entry_count", 32'(want_res.entry_count),
                      32'(out_data.entry_count));
          check_field("cursor_valid", 32'(want_res.cursor_valid),
                      32'(out_data.cursor_valid));
          check_field("cursor_position", 32'(want_res.cursor_position),
                      32'(out_data.cursor_position));
          check_field("found_position", 32'(want_res.found_position),
                      32'(out_data.found_position));
          check_field("revision", want_res.revision, out_data.revision);
        end
      end
      if (in_valid && !in_stall) begin
        list_results.push_back(list_update(in_data));
        req_taken = 1'b1;
      end
    end
  end

  // Request driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (gap_left > 0 || pending_requests.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 2);
        end
      end
    end
  end

  // Result stall: switch between free-running, random, long and sparse stalls
  always @(negedge clk) begin
    if (stall_hold > 0) stall_hold--;
    else begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(20, 200);
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 1);
      2:       out_stall <= ((stall_hold % 32) < 24);
      default: out_stall <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic push_req(input logic [2:0] cmd, input logic [oclc_pkg::ID_BITS-1:0] cid,
                          input logic [oclc_pkg::ID_BITS-1:0] nid, input int pos,
                          input bit app);
    oclc_pkg::in_req_t r;
    r.cmd      = cmd;
    r.child_id = cid;
    r.new_id   = nid;
    r.position = oclc_pkg::CNT_BITS'(pos);
    r.append   = app;
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  // Mostly pool IDs, so stored entries can be removed again
  function automatic logic [oclc_pkg::ID_BITS-1:0] pick_id(input bit wild);
    int roll;
    roll = $urandom_range(0, 31);
    if (roll == 0) return oclc_pkg::ID_NONE;
    if (wild && roll == 1) return oclc_pkg::ID_BITS'($urandom_range(0, 65535));
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic queue_random(input int n, input int insert_weight);
    logic [2:0] cmd;
    int         roll;
    int         pos;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_weight) cmd = oclc_pkg::CMD_INSERT;
      else begin
        roll = $urandom_range(0, 99);
        if (roll < 35) cmd = oclc_pkg::CMD_REMOVE;
        else if (roll < 55) cmd = oclc_pkg::CMD_REPLACE;
        else if (roll < 80) cmd = oclc_pkg::CMD_MOVE;
        else if (roll < 96) cmd = oclc_pkg::CMD_FIND;
        else cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      end
      roll = $urandom_range(0, 15);
      if (roll == 0) pos = $urandom_range(oclc_pkg::MAX_ENTRIES + 1, 31);
      else if (roll < 8) pos = $urandom_range(0, 5);
      else pos = $urandom_range(0, oclc_pkg::MAX_ENTRIES);
      push_req(cmd, pick_id(cmd != oclc_pkg::CMD_INSERT), pick_id(1'b0), pos,
               $urandom_range(0, 1));
    end
  endtask

  // Hold until every queued request has returned its result
  task automatic settle();
    while (results_seen < requests_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_container(input bit v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    container = v;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int ins_weight [PHASES];
    bit phase_cfg  [PHASES];
    ins_weight = '{70, 40, 30, 10, 55, 35};
    phase_cfg  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFE;
    id_pool[2] = 16'h5555;
    id_pool[3] = 16'hAAAA;
    for (int i = 4; i < POOL_SIZE; i++) begin
      id_pool[i] = oclc_pkg::ID_BITS'($urandom_range(0, 65534));
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list corner cases
    push_req(oclc_pkg::CMD_FIND, 16'h1234, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_REMOVE, 16'h1234, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_MOVE, 16'h1234, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_INSERT, oclc_pkg::ID_NONE, 16'h0000, 0, 1'b1);
    push_req(oclc_pkg::CMD_INSERT, 16'h0000, 16'h0000, 1, 1'b0);
    // Build a three-entry list, append ignores position
    push_req(oclc_pkg::CMD_INSERT, 16'h0000, 16'h0000, 31, 1'b1);
    push_req(oclc_pkg::CMD_INSERT, 16'hFFFE, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_INSERT, 16'h0000, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_INSERT, 16'h8001, 16'h0000, 1, 1'b0);
    // Replace checks in order
    push_req(oclc_pkg::CMD_REPLACE, 16'h8001, oclc_pkg::ID_NONE, 0, 1'b0);
    push_req(oclc_pkg::CMD_REPLACE, 16'h8001, 16'hFFFE, 0, 1'b0);
    push_req(oclc_pkg::CMD_REPLACE, 16'h1111, 16'h2222, 0, 1'b0);
    push_req(oclc_pkg::CMD_REPLACE, 16'h8001, 16'h7FFE, 0, 1'b0);
    // Moves: active entry, to the last place, out of range, absent, crossing cursor
    push_req(oclc_pkg::CMD_MOVE, 16'h0000, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_MOVE, 16'hFFFE, 16'h0000, 2, 1'b0);
    push_req(oclc_pkg::CMD_MOVE, 16'h7FFE, 16'h0000, 3, 1'b0);
    push_req(oclc_pkg::CMD_MOVE, 16'h1111, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_MOVE, 16'h7FFE, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_FIND, 16'h7FFE, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_FIND, oclc_pkg::ID_NONE, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_REMOVE, oclc_pkg::ID_NONE, 16'h0000, 0, 1'b0);
    push_req(CMD_UNKNOWN_LO, 16'h0000, 16'h0000, 0, 1'b0);
    push_req(CMD_UNKNOWN_HI, oclc_pkg::ID_NONE, oclc_pkg::ID_NONE, 31, 1'b1);
    // Remove the active entry twice, then empty the list
    push_req(oclc_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_REMOVE, 16'hFFFE, 16'h0000, 0, 1'b0);
    push_req(oclc_pkg::CMD_REMOVE, 16'h7FFE, 16'h0000, 0, 1'b0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_container(phase_cfg[ph]);
      queue_random(PHASE_ITEMS, ins_weight[ph]);
      settle();
    end

    $display("Checked %0d results: %0d rejected requests, %0d lookups, final revision %0d.",
             results_seen, n_rejected, n_finds, rev);
    $display("List filled to %0d of %0d entries under both container settings.",
             max_fill, oclc_pkg::MAX_ENTRIES);
    if (error_count == 0 && list_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/oclc_pkg.sv
rtl/oclc_id_mem.sv
rtl/oclc_engine.sv
rtl/ordered_child_list_with_cursor_unit.sv
tb/testbench.sv
